/* sv/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; the including scope provides clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// concurrent assertion on the default clock and reset names
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

/* sv/fbfla_pkg.sv */
// shared types and constants of the fixed block free list allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbfla_pkg;

  // field widths
  localparam int IdxW   = 10;
  localparam int CountW = 11;

  // defaults and limits
  localparam int                NumBlocksDef  = 1024;
  localparam logic [CountW-1:0] CountMax      = 11'h7FF;
  localparam logic [CountW-1:0] BlockCountRst = 11'd1024;

  // request codes
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_RESET = 2'd2,
    REQ_COUNT = 2'd3
  } req_type_e;

  // status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  // input transaction
  typedef struct packed {
    logic [1:0]      req_type;
    logic [IdxW-1:0] free_index;
  } req_t;

  // result transaction
  typedef struct packed {
    status_e           status;
    logic [IdxW-1:0]   block_index;
    logic [CountW-1:0] free_count;
  } rsp_t;

  // configuration to control path
  typedef struct packed {
    logic              reinit;
    logic [CountW-1:0] eff_count;
    logic [CountW-1:0] eff_new;
  } cfg_t;

  // link memory access
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

/* sv/fbfla_link_mem.sv */
// link store: one write port, one registered read port
// depends on fbfla_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbfla_link_mem #(
  parameter int NumBlocks = fbfla_pkg::NumBlocksDef
) (
  input  wire logic                       clk_i,
  input  wire fbfla_pkg::mem_req_t        mem_i,
  output logic [fbfla_pkg::IdxW-1:0]      rdata_o
);

  localparam int AddrW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;

  logic [fbfla_pkg::IdxW-1:0] mem_q [NumBlocks];

  // write port
  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[AddrW'(mem_i.waddr)] <= mem_i.wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[AddrW'(mem_i.raddr)];
  end

endmodule

`default_nettype wire

/* sv/fbfla_cfg.sv */
// apb register file holding block_count
// depends on fbfla_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbfla_cfg #(
  parameter int NumBlocks = fbfla_pkg::NumBlocksDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output fbfla_pkg::cfg_t         cfg_o
);

  localparam logic [fbfla_pkg::CountW-1:0] SatCount =
    fbfla_pkg::CountW'((NumBlocks > 2047) ? 2047 : NumBlocks);

  logic [fbfla_pkg::CountW-1:0] block_count_q, block_count_d;
  logic                         reg_hit;
  logic                         wr_en;

  // only word 0 holds a register
  assign reg_hit = ~paddr[2];
  assign wr_en   = psel & penable & pwrite & reg_hit;
  assign pready  = 1'b1;

  always_comb begin
    block_count_d = block_count_q;
    if (wr_en) begin
      block_count_d = pwdata[fbfla_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= fbfla_pkg::BlockCountRst;
    end else begin
      block_count_q <= block_count_d;
    end
  end

  // read data
  assign prdata = reg_hit ? {21'd0, block_count_q} : 32'd0;

  // saturated pool size, current and being written
  assign cfg_o.reinit    = wr_en;
  assign cfg_o.eff_count = (block_count_q > SatCount) ? SatCount : block_count_q;
  assign cfg_o.eff_new   = (block_count_d > SatCount) ? SatCount : block_count_d;

endmodule

`default_nettype wire

/* sv/fbfla_ctrl.sv */
// allocator control: list head, watermark, free count, result register
// depends on fbfla_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbfla_ctrl #(
  parameter int NumBlocks = fbfla_pkg::NumBlocksDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire fbfla_pkg::req_t            req_i,
  input  wire fbfla_pkg::cfg_t            cfg_i,
  input  wire logic [fbfla_pkg::IdxW-1:0] rdata_i,
  output fbfla_pkg::mem_req_t             mem_o,
  output logic                            done_o,
  output fbfla_pkg::rsp_t                 rsp_o
);

  localparam int CW = fbfla_pkg::CountW;
  localparam int IW = fbfla_pkg::IdxW;
  localparam logic [CW-1:0] RstCount =
    CW'((NumBlocks > 1024) ? 1024 : NumBlocks);

  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] mark_q, mark_d;
  logic [CW-1:0] free_q, free_d;
  logic          fwd_q, fwd_d;
  logic [IW-1:0] fwd_data_q, fwd_data_d;
  logic          done_q;
  fbfla_pkg::rsp_t rsp_q, rsp_d;

  logic [CW-1:0] n;
  logic [CW-1:0] pushed;
  logic [IW-1:0] next_head;

  assign n      = cfg_i.eff_count;
  assign pushed = CW'(free_q - n + mark_q);

  // link of the current head, forwarded when it was written last cycle
  assign next_head = fwd_q ? fwd_data_q : rdata_i;

  // request decode and state update
  always_comb begin
    head_d     = head_q;
    mark_d     = mark_q;
    free_d     = free_q;
    fwd_d      = 1'b0;
    fwd_data_d = fwd_data_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = req_i.free_index;
    mem_o.wdata = '0;
    rsp_d.status      = fbfla_pkg::ST_OK;
    rsp_d.block_index = '0;
    if (cfg_i.reinit) begin
      mark_d = '0;
      free_d = cfg_i.eff_new;
    end else if (accept_i) begin
      unique case (fbfla_pkg::req_type_e'(req_i.req_type))
        fbfla_pkg::REQ_ALLOC: begin
          if (pushed != '0) begin
            rsp_d.block_index = head_q;
            if (pushed > CW'(1)) begin
              head_d = next_head;
            end
            free_d = free_q - CW'(1);
          end else if (mark_q < n) begin
            rsp_d.block_index = mark_q[IW-1:0];
            mark_d = mark_q + CW'(1);
            free_d = free_q - CW'(1);
          end else begin
            rsp_d.status = fbfla_pkg::ST_EXHAUSTED;
          end
        end
        fbfla_pkg::REQ_FREE: begin
          if ({1'b0, req_i.free_index} >= n) begin
            rsp_d.status = fbfla_pkg::ST_RANGE;
          end else if (free_q != fbfla_pkg::CountMax) begin
            mem_o.we    = 1'b1;
            mem_o.wdata = (pushed != '0) ? head_q : '0;
            head_d      = req_i.free_index;
            free_d      = free_q + CW'(1);
            fwd_d       = 1'b1;
            fwd_data_d  = mem_o.wdata;
          end
        end
        fbfla_pkg::REQ_RESET: begin
          mark_d = '0;
          free_d = n;
        end
        fbfla_pkg::REQ_COUNT: begin
        end
        default: begin
        end
      endcase
    end
    rsp_d.free_count = free_d;
    // keep the link of the next head prefetched
    mem_o.raddr = head_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      mark_q <= '0;
      free_q <= RstCount;
      fwd_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      head_q <= head_d;
      mark_q <= mark_d;
      free_q <= free_d;
      fwd_q  <= fwd_d;
      done_q <= accept_i & ~cfg_i.reinit;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fwd_data_q <= fwd_data_d;
    rsp_q      <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

/* sv/fixed_block_free_list_allocator.sv */
// top level of the fixed block free list allocator
// depends on fbfla_pkg, fbfla_cfg, fbfla_ctrl, fbfla_link_mem
//
// Hands out equal blocks of a pool by index through a last-in-first-out
// free list backed by a link memory, plus a watermark for untouched blocks.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; req_i carries the request type and, for a free, the index.
// busy stays low, so one request is taken in every cycle.
// Result channel: done_o is high for exactly one cycle, in the cycle after the
// request is taken, with status, allocated index and free count on rsp_o.
// The receiver cannot stall; each result must be taken in its cycle.
// Throughput is one request per cycle. The link of the list head is read
// from the registered link memory in advance and forwarded after a free,
// so back-to-back allocates and frees never wait.
// Configuration: block_count at apb byte address 0; a write re-initializes
// the pool. Write only while no request is in flight.
// Reset: block_count returns to 1024 and every block is free, so the first
// allocate returns block 0. The link memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator #(
  parameter int NUM_BLOCKS = fbfla_pkg::NumBlocksDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire fbfla_pkg::req_t  req_i,
  output logic                  done_o,
  output fbfla_pkg::rsp_t       rsp_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  fbfla_pkg::cfg_t              cfg;
  fbfla_pkg::mem_req_t          mem_req;
  logic [fbfla_pkg::IdxW-1:0]   link_rdata;
  logic                         accept;

  // a request is taken every cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  fbfla_cfg #(
    .NumBlocks (NUM_BLOCKS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fbfla_ctrl #(
    .NumBlocks (NUM_BLOCKS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .cfg_i    (cfg),
    .rdata_i  (link_rdata),
    .mem_o    (mem_req),
    .done_o   (done_o),
    .rsp_o    (rsp_o)
  );

  fbfla_link_mem #(
    .NumBlocks (NUM_BLOCKS)
  ) u_link_mem (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (link_rdata)
  );

endmodule

`default_nettype wire

/* sv/fbfla_checker.sv */
// port-level checker for the allocator, bound to the top level
// depends on fbfla_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fbfla_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire fbfla_pkg::req_t req_i,
  input wire logic            done_o,
  input wire fbfla_pkg::rsp_t rsp_o
);

  // every taken transaction gives a result in the next cycle
  `ASSERT_DEF(a_accept_done, (start && !busy) |=> done_o, "result missing after request")

  // no result without a taken transaction
  `ASSERT_DEF(a_done_origin, done_o |-> $past(start && !busy), "result without request")

  // exhaustion means nothing free and no index
  `ASSERT_DEF(a_exhausted, (done_o && rsp_o.status == fbfla_pkg::ST_EXHAUSTED) |-> (rsp_o.free_count == '0 && rsp_o.block_index == '0), "exhausted with blocks free")

  // range error comes only from a free
  `ASSERT_DEF(a_range_free, (done_o && rsp_o.status == fbfla_pkg::ST_RANGE) |-> ($past(req_i.req_type) == fbfla_pkg::REQ_FREE), "range error on non-free request")

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_fbfla_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
